FILE: rtl/core/hahr_pkg.sv
// Shared types and constants for the hourly average history ring.
// Holds item structs, register indexes and control structs; no dependencies.
package hahr_pkg;

  localparam int HistDepth  = 24;
  localparam int HIST_AW    = $clog2(HistDepth);
  localparam int FILL_W     = $clog2(HistDepth + 1);
  localparam int TEMP_W     = 12;
  localparam int TIME_W     = 32;
  localparam int SUM_W      = 28;
  localparam int CNT_W      = 16;
  localparam int BUCKETS_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [TEMP_W-1:0] ValidMinRst = 12'sd80;
  localparam logic signed [TEMP_W-1:0] ValidMaxRst = 12'sd640;
  localparam logic [TIME_W-1:0]        BucketPeriodRst = 32'd3600000;
  localparam logic [TIME_W-1:0]        SendIntervalRst = 32'd300000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VALID_MIN     = 2'd0,
    CFG_VALID_MAX     = 2'd1,
    CFG_BUCKET_PERIOD = 2'd2,
    CFG_SEND_INTERVAL = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [TIME_W-1:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic                     sample_valid;
    logic                     bucket_closed;
    logic signed [TEMP_W-1:0] closed_average;
    logic [BUCKETS_W-1:0]     buckets_filled;
    logic                     window_has_value;
    logic signed [TEMP_W-1:0] window_min;
    logic signed [TEMP_W-1:0] window_max;
    logic                     send_now;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic scan_start;
  } hist_ctrl_t;

  typedef struct packed {
    logic                     done;
    logic                     have;
    logic signed [TEMP_W-1:0] min;
    logic signed [TEMP_W-1:0] max;
  } hist_stat_t;

endpackage

FILE: rtl/core/hahr_div.sv
// Iterative signed divider: period sum by sample count, truncated toward zero.
// One quotient bit per cycle; depends on hahr_pkg.
module hahr_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [hahr_pkg::SUM_W-1:0] dividend_i,
  input  logic [hahr_pkg::CNT_W-1:0]       divisor_i,
  output logic                             done_o,
  output logic signed [hahr_pkg::TEMP_W-1:0] quotient_o
);
  import hahr_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [SUM_W-1:0]    dq_q, dq_d;
  logic [CNT_W-1:0]    dsr_q, dsr_d;
  logic                neg_q, neg_d;
  logic [CNT_W:0]      shifted;
  logic [CNT_W+1:0]    diff;
  logic                ge;
  logic [SUM_W-1:0]    quo_full;

  assign shifted  = {rem_q, dq_q[SUM_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dsr_q};
  assign ge       = ~diff[CNT_W+1];
  assign quo_full = neg_q ? (~dq_q + 1'b1) : dq_q;
  assign quotient_o = quo_full[TEMP_W-1:0];
  assign done_o   = done_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SUM_W - 1);
      rem_d  = '0;
      dsr_d  = divisor_i;
      neg_d  = dividend_i[SUM_W-1];
      dq_d   = dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      dq_d  = {dq_q[SUM_W-2:0], ge};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

endmodule

FILE: rtl/core/hahr_hist.sv
// History ring memory with a sequential min/max scan over the filled entries.
// One entry read per cycle through a registered port; depends on hahr_pkg.
module hahr_hist (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hahr_pkg::hist_ctrl_t               ctrl_i,
  input  logic [hahr_pkg::HIST_AW-1:0]       wr_addr_i,
  input  logic signed [hahr_pkg::TEMP_W-1:0] wr_data_i,
  input  logic [hahr_pkg::FILL_W-1:0]        scan_len_i,
  output hahr_pkg::hist_stat_t               stat_o
);
  import hahr_pkg::*;

  logic signed [TEMP_W-1:0] mem [HistDepth];
  logic signed [TEMP_W-1:0] rd_q;
  logic                     rv_q, rv_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [FILL_W-1:0]        idx_q, idx_d;
  logic [FILL_W-1:0]        len_q, len_d;
  logic                     have_q, have_d;
  logic signed [TEMP_W-1:0] min_q, min_d;
  logic signed [TEMP_W-1:0] max_q, max_d;
  logic                     issue;

  assign issue = busy_q && (idx_q < len_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (issue) begin
      rd_q <= mem[idx_q[HIST_AW-1:0]];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    idx_d  = idx_q;
    len_d  = len_q;
    have_d = have_q;
    min_d  = min_q;
    max_d  = max_q;
    rv_d   = issue;
    if (ctrl_i.scan_start) begin
      busy_d = 1'b1;
      idx_d  = '0;
      len_d  = scan_len_i;
      have_d = 1'b0;
      rv_d   = 1'b0;
    end else if (busy_q) begin
      if (issue) begin
        idx_d = idx_q + 1'b1;
      end
      if (rv_q) begin
        have_d = 1'b1;
        if (!have_q || rd_q < min_q) min_d = rd_q;
        if (!have_q || rd_q > max_q) max_d = rd_q;
      end
      if (!issue && !rv_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rv_q   <= 1'b0;
      idx_q  <= '0;
      len_q  <= '0;
      have_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rv_q   <= rv_d;
      idx_q  <= idx_d;
      len_q  <= len_d;
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    max_q <= max_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.have = have_q;
  assign stat_o.min  = min_q;
  assign stat_o.max  = max_q;

endmodule

FILE: rtl/core/hourly_average_history_ring_top.sv
// Hourly average history ring: sequencer, accumulators, send timer and output register.
// An item is captured, then evaluated; one that closes a bucket runs the divider
// and a history write; then the history is scanned and the result is registered out.
// One item at a time; the next item is taken in the cycle after the result loads.
// Reset clears all control state, accumulators and timers; history entries are undefined.
// Depends on hahr_pkg, hahr_div and hahr_hist.
module hourly_average_history_ring_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  hahr_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output hahr_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [hahr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hahr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import hahr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_WRITE,
    ST_SCAN,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  logic signed [TEMP_W-1:0] vmin_q, vmin_d;
  logic signed [TEMP_W-1:0] vmax_q, vmax_d;
  logic [TIME_W-1:0]        period_q, period_d;
  logic [TIME_W-1:0]        interval_q, interval_d;

  logic signed [TEMP_W-1:0] t_q, t_d;
  logic [TIME_W-1:0]        now_q, now_d;

  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [TIME_W-1:0]        start_q, start_d;
  logic [TIME_W-1:0]        last_q, last_d;
  logic                     sent_q, sent_d;
  logic [FILL_W-1:0]        filled_q, filled_d;
  logic [HIST_AW-1:0]       oldest_q, oldest_d;

  logic                     rvalid_q, rvalid_d;
  logic                     rclose_q, rclose_d;
  logic                     rsend_q, rsend_d;
  logic signed [TEMP_W-1:0] avg_q, avg_d;
  logic                     whave_q, whave_d;
  logic signed [TEMP_W-1:0] wmin_q, wmin_d;
  logic signed [TEMP_W-1:0] wmax_q, wmax_d;

  logic                     out_valid_q, out_valid_d;
  out_item_t                out_q, out_d;

  logic                     smp_valid;
  logic                     cnt_sat;
  logic signed [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]         cnt_new;
  logic [TIME_W-1:0]        elapsed;
  logic [TIME_W-1:0]        since_send;
  logic                     close;
  logic                     send;

  logic                     div_start;
  logic                     div_done;
  logic signed [TEMP_W-1:0] div_quo;

  hist_ctrl_t               hctrl;
  hist_stat_t               hstat;
  logic [HIST_AW-1:0]       wr_addr;

  assign smp_valid  = (t_q >= vmin_q) && (t_q <= vmax_q);
  assign cnt_sat    = &cnt_q;
  assign sum_new    = cnt_sat ? sum_q : (sum_q + SUM_W'(t_q));
  assign cnt_new    = cnt_sat ? cnt_q : (cnt_q + 1'b1);
  assign elapsed    = now_q - start_q;
  assign since_send = now_q - last_q;
  assign close      = smp_valid && (elapsed >= period_q);
  assign send       = smp_valid && (!sent_q || (since_send >= interval_q));
  assign wr_addr    = (filled_q < FILL_W'(HistDepth)) ? filled_q[HIST_AW-1:0] : oldest_q;

  hahr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (cnt_new),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  hahr_hist u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (hctrl),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (avg_q),
    .scan_len_i (filled_d),
    .stat_o     (hstat)
  );

  always_comb begin
    state_d     = state_q;
    vmin_d      = vmin_q;
    vmax_d      = vmax_q;
    period_d    = period_q;
    interval_d  = interval_q;
    t_d         = t_q;
    now_d       = now_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    start_d     = start_q;
    last_d      = last_q;
    sent_d      = sent_q;
    filled_d    = filled_q;
    oldest_d    = oldest_q;
    rvalid_d    = rvalid_q;
    rclose_d    = rclose_q;
    rsend_d     = rsend_q;
    avg_d       = avg_q;
    whave_d     = whave_q;
    wmin_d      = wmin_q;
    wmax_d      = wmax_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    div_start   = 1'b0;
    hctrl       = '0;

    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VALID_MIN:     vmin_d     = cfg_data_i[TEMP_W-1:0];
        CFG_VALID_MAX:     vmax_d     = cfg_data_i[TEMP_W-1:0];
        CFG_BUCKET_PERIOD: period_d   = cfg_data_i[TIME_W-1:0];
        CFG_SEND_INTERVAL: interval_d = cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          t_d     = in_item_i.temperature;
          now_d   = in_item_i.time_ms;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        rvalid_d = smp_valid;
        rclose_d = close;
        rsend_d  = send;
        avg_d    = '0;
        if (smp_valid) begin
          sum_d = sum_new;
          cnt_d = cnt_new;
        end
        if (send) begin
          last_d = now_q;
          sent_d = 1'b1;
        end
        if (close) begin
          div_start = 1'b1;
          sum_d     = '0;
          cnt_d     = '0;
          start_d   = start_q + period_q;
          state_d   = ST_DIV;
        end else begin
          hctrl.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          avg_d   = div_quo;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        hctrl.wr_en      = 1'b1;
        hctrl.scan_start = 1'b1;
        if (filled_q < FILL_W'(HistDepth)) begin
          filled_d = filled_q + 1'b1;
        end else if (oldest_q == HIST_AW'(HistDepth - 1)) begin
          oldest_d = '0;
        end else begin
          oldest_d = oldest_q + 1'b1;
        end
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (hstat.done) begin
          whave_d = hstat.have || rvalid_q;
          if (hstat.have) begin
            wmin_d = (rvalid_q && (t_q < hstat.min)) ? t_q : hstat.min;
            wmax_d = (rvalid_q && (t_q > hstat.max)) ? t_q : hstat.max;
          end else if (rvalid_q) begin
            wmin_d = t_q;
            wmax_d = t_q;
          end else begin
            wmin_d = '0;
            wmax_d = '0;
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_d.sample_valid     = rvalid_q;
          out_d.bucket_closed    = rclose_q;
          out_d.closed_average   = avg_q;
          out_d.buckets_filled   = BUCKETS_W'(filled_q);
          out_d.window_has_value = whave_q;
          out_d.window_min       = wmin_q;
          out_d.window_max       = wmax_q;
          out_d.send_now         = rsend_q;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vmin_q      <= ValidMinRst;
      vmax_q      <= ValidMaxRst;
      period_q    <= BucketPeriodRst;
      interval_q  <= SendIntervalRst;
      sum_q       <= '0;
      cnt_q       <= '0;
      start_q     <= '0;
      last_q      <= '0;
      sent_q      <= 1'b0;
      filled_q    <= '0;
      oldest_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      vmin_q      <= vmin_d;
      vmax_q      <= vmax_d;
      period_q    <= period_d;
      interval_q  <= interval_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      start_q     <= start_d;
      last_q      <= last_d;
      sent_q      <= sent_d;
      filled_q    <= filled_d;
      oldest_q    <= oldest_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    now_q    <= now_d;
    rvalid_q <= rvalid_d;
    rclose_q <= rclose_d;
    rsend_q  <= rsend_d;
    avg_q    <= avg_d;
    whave_q  <= whave_d;
    wmin_q   <= wmin_d;
    wmax_q   <= wmax_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
